### hw/rtl/mdfc_pkg.sv
// ----------------------------------------------------------------------------
// mdfc_pkg: shared types and constants of the music ducking fade controller
// Gain format, register reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package mdfc_pkg;

  localparam int unsigned GAIN_W = 17;

  // Q1.16 unity gain.
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  localparam logic [GAIN_W-1:0] FADE_OUT_STEP_RST = 17'd1311;
  localparam logic [GAIN_W-1:0] FADE_IN_STEP_RST  = 17'd262;

  typedef struct packed {
    logic [GAIN_W-1:0] fade_out_step;
    logic [GAIN_W-1:0] fade_in_step;
  } cfg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] duck_gain;
    logic              duck_active;
    logic              pause_music;
    logic              resume_music;
    logic [1:0]        phase;
  } res_t;

endpackage

### hw/rtl/music_ducking_fade_controller_unit.sv
// ----------------------------------------------------------------------------
// music_ducking_fade_controller_unit: music ducking fade controller
// Fades music down around a jingle, pauses and resumes it, fades it back.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transfer (in_valid/in_ready) is one tick carrying the jingle
//   and music stream status. Each tick produces exactly one output transfer
//   (out_valid/out_ready) with the Q1.16 music gain, the duck flag, pause
//   and resume commands and the new phase.
//   Each result is registered in the output buffer. Throughput is one tick
//   per cycle while in_ready is high; the phase and gain update is a single
//   add or subtract and compare between the state registers.
//   The output side has a result register plus one skid entry, so a tick is
//   still taken while one result waits; in_ready drops only when both
//   entries are full and recovers the cycle after the receiver takes one.
//   Reset (rst, synchronous) returns to idle with unity gain, duck flag
//   clear, empty output buffer and default fade steps (1311 out, 262 in).
//   Fade steps are written over the APB port at offsets 0x0 and 0x4; the user
//   must do so only while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module music_ducking_fade_controller_unit import mdfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              jingle_playing,
  input  logic [1:0]        music_state,
  input  logic              no_resume,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [GAIN_W-1:0] duck_gain,
  output logic              duck_active,
  output logic              pause_music,
  output logic              resume_music,
  output logic [1:0]        phase
);

  cfg_t cfg;
  res_t res;
  res_t out_data;
  logic tick;

  assign tick = in_valid && in_ready;

  mdfc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mdfc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .jingle_playing (jingle_playing),
    .music_state    (music_state),
    .no_resume      (no_resume),
    .cfg            (cfg),
    .res            (res)
  );

  mdfc_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (tick),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign duck_gain    = out_data.duck_gain;
  assign duck_active  = out_data.duck_active;
  assign pause_music  = out_data.pause_music;
  assign resume_music = out_data.resume_music;
  assign phase        = out_data.phase;

endmodule

### hw/rtl/mdfc_cfg.sv
// ----------------------------------------------------------------------------
// mdfc_cfg: configuration registers
// APB-style write and read access to the two fade step registers.
// ----------------------------------------------------------------------------
module mdfc_cfg import mdfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  typedef enum logic {
    REG_FADE_OUT = 1'b0,
    REG_FADE_IN  = 1'b1
  } reg_idx_t;

  logic     wr_en;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  // Registers are word aligned; the byte offset bits are ignored.
  assign sel    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fade_out_step <= FADE_OUT_STEP_RST;
      cfg.fade_in_step  <= FADE_IN_STEP_RST;
    end else if (wr_en) begin
      unique case (sel)
        REG_FADE_OUT: cfg.fade_out_step <= pwdata[GAIN_W-1:0];
        REG_FADE_IN:  cfg.fade_in_step  <= pwdata[GAIN_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_FADE_OUT: prdata = {{(32-GAIN_W){1'b0}}, cfg.fade_out_step};
      REG_FADE_IN:  prdata = {{(32-GAIN_W){1'b0}}, cfg.fade_in_step};
      default:      prdata = '0;
    endcase
  end

endmodule

### hw/rtl/mdfc_core.sv
// ----------------------------------------------------------------------------
// mdfc_core: ducking phase and gain update
// Holds the phase, gain and duck flag and computes one result per tick.
// ----------------------------------------------------------------------------
module mdfc_core import mdfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic       jingle_playing,
  input  logic [1:0] music_state,
  input  logic       no_resume,
  input  cfg_t       cfg,
  output res_t       res
);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_FADE_OUT = 2'd1,
    PH_JINGLE   = 2'd2,
    PH_FADE_IN  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MUS_STOPPED = 2'd0,
    MUS_PLAYING = 2'd1,
    MUS_PAUSED  = 2'd2,
    MUS_OTHER   = 2'd3
  } music_t;

  phase_t            phase, phase_next;
  logic [GAIN_W-1:0] gain, gain_next;
  logic              duck, duck_next;
  logic              pause_cmd, resume_cmd;
  music_t            ms;
  logic [GAIN_W:0]   diff, sum;

  assign ms   = music_t'(music_state);
  assign diff = {1'b0, gain} - {1'b0, cfg.fade_out_step};
  assign sum  = {1'b0, gain} + {1'b0, cfg.fade_in_step};

  always_comb begin
    phase_next = phase;
    gain_next  = gain;
    duck_next  = duck;
    pause_cmd  = 1'b0;
    resume_cmd = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (jingle_playing) begin
          duck_next  = 1'b1;
          phase_next = PH_FADE_OUT;
        end
      end
      PH_FADE_OUT: begin
        if (!jingle_playing) begin
          duck_next  = 1'b0;
          phase_next = PH_FADE_IN;
        end else if (diff[GAIN_W] || ms != MUS_PLAYING) begin
          // The borrow bit marks a step that went below zero.
          gain_next  = '0;
          pause_cmd  = 1'b1;
          phase_next = PH_JINGLE;
        end else begin
          gain_next = diff[GAIN_W-1:0];
        end
      end
      PH_JINGLE: begin
        if (!jingle_playing) begin
          duck_next = 1'b0;
          if (ms == MUS_PAUSED) begin
            resume_cmd = 1'b1;
            phase_next = PH_FADE_IN;
          end else begin
            gain_next  = GAIN_ONE;
            resume_cmd = !no_resume;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_FADE_IN: begin
        // Unknown music state code counts as stopped.
        if (ms == MUS_STOPPED || ms == MUS_OTHER) begin
          gain_next  = GAIN_ONE;
          phase_next = PH_IDLE;
        end else if (jingle_playing) begin
          duck_next  = 1'b1;
          phase_next = PH_FADE_OUT;
        end else if (sum >= {1'b0, GAIN_ONE}) begin
          gain_next  = GAIN_ONE;
          phase_next = PH_IDLE;
        end else begin
          gain_next = sum[GAIN_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      gain  <= GAIN_ONE;
      duck  <= 1'b0;
    end else if (tick) begin
      phase <= phase_next;
      gain  <= gain_next;
      duck  <= duck_next;
    end
  end

  always_comb begin
    res.duck_gain    = gain_next;
    res.duck_active  = duck_next;
    res.pause_music  = pause_cmd;
    res.resume_music = resume_cmd;
    res.phase        = phase_next;
  end

`ifndef SYNTHESIS
  a_idle_unity: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> gain == GAIN_ONE && !duck)
    else $error("idle phase without unity gain or with duck flag set");

  a_jingle_muted: assert property (@(posedge clk) disable iff (rst)
    phase == PH_JINGLE |-> gain == '0 && duck)
    else $error("jingle phase with nonzero gain or duck flag clear");

  a_fade_flag: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FADE_OUT |-> duck) and (phase == PH_FADE_IN |-> !duck))
    else $error("duck flag does not match fade direction");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    gain <= GAIN_ONE)
    else $error("gain above unity");
`endif

endmodule

### hw/rtl/mdfc_obuf.sv
// ----------------------------------------------------------------------------
// mdfc_obuf: result register with skid entry
// Holds up to two results so the input side keeps moving under a stall.
// ----------------------------------------------------------------------------
module mdfc_obuf import mdfc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  res_t skid;
  logic skid_valid;
  logic pop;

  assign space = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      if (push) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid       <= push_data;
      skid_valid <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while result register is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("transfer accepted with both entries full");
`endif

endmodule
